FILE: rtl/ebc_pkg.sv
`timescale 1ns / 1ps

package ebc_pkg;

  // Fixed field widths
  localparam int LVL_W      = 6;
  localparam int DIR_W      = 2;
  localparam int CAR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int RUN_W      = 4;
  localparam int SCORE_W    = 7;

  localparam int DEF_CARS    = 4;
  localparam int DEF_FLOORS  = 64;
  localparam int MAX_REPORTS = 4;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 7'h7f;

  localparam logic [LVL_W-1:0] MIN_FLOOR_RST = 6'd1;
  localparam logic [LVL_W-1:0] MAX_FLOOR_RST = 6'd10;
  localparam logic [RUN_W-1:0] RUN_MASK_RST  = 4'd0;

  // Car direction codes
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_STAND = 2'd2;

  // Input opcodes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Result kinds
  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Status codes
  localparam logic ST_OK        = 1'b0;
  localparam logic ST_BAD_FLOOR = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MASK  = 2'd2;

endpackage

FILE: rtl/elevator_bank_controller.sv
`timescale 1ns / 1ps
// Elevator bank controller.
// Input channel (in_valid/in_ready): one item per hall request (opcode 0, floor)
// or per time tick (opcode 1). Output channel (out_valid/out_ready): one
// answer item per request, one report item per car after a tick (at most
// four, the final one flagged by last).
// Car state (level, direction, pending floor bitmap) lives in a single-port
// memory with a registered read; each item visits the cars in index order,
// with a read state and an evaluate state per car.
// A new item is accepted only after the previous one has finished its pass
// over the cars. The answer is loaded once every car has been evaluated;
// the report for car i is loaded when car i is evaluated.
// Reset: min_floor 1, max_floor 10, run_mask 0; all cars read as homed at
// min_floor, standing, with no pending floors. A write to min_floor re-homes
// every car the same way. Configuration is written through cfg_we/cfg_addr/
// cfg_wdata; the user must do so only while the block is idle (not enforced).
// Stall: results sit in an output register; while it is full and not taken,
// the sequencer holds on the report or answer to be loaded; in_ready stays low.
module elevator_bank_controller #(
  parameter int CARS   = ebc_pkg::DEF_CARS,
  parameter int FLOORS = ebc_pkg::DEF_FLOORS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic [ebc_pkg::LVL_W-1:0]      floor,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           kind,
  output logic [ebc_pkg::CAR_W-1:0]      car,
  output logic                           status,
  output logic [ebc_pkg::LVL_W-1:0]      level,
  output logic [ebc_pkg::DIR_W-1:0]      direction,
  output logic                           door_opened,
  output logic                           last,
  input  logic                           cfg_we,
  input  logic [ebc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ebc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CIDX_W = (CARS > 1) ? $clog2(CARS) : 1;
  localparam int IDXX_W = CIDX_W + 2;
  localparam logic [CIDX_W-1:0] LAST_CAR = CIDX_W'(CARS - 1);
  localparam logic [IDXX_W-1:0] LAST_REPORT = IDXX_W'(ebc_pkg::MAX_REPORTS - 1);
  localparam logic [ebc_pkg::LVL_W:0] FLOOR_LIMIT = (ebc_pkg::LVL_W + 1)'(FLOORS);
  localparam logic [ebc_pkg::LVL_W:0] TOP_FLOOR   = (ebc_pkg::LVL_W + 1)'(FLOORS - 1);

  typedef struct packed {
    logic [ebc_pkg::LVL_W-1:0] lvl;
    logic [ebc_pkg::DIR_W-1:0] dir;
    logic [FLOORS-1:0]         pend;
  } car_t;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_READ     = 4'b0010,
    S_EVAL     = 4'b0100,
    S_REQ_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [ebc_pkg::LVL_W-1:0] min_floor;
  logic [ebc_pkg::LVL_W-1:0] max_floor;
  logic [ebc_pkg::RUN_W-1:0] run_mask;

  logic                      op_q;
  logic [ebc_pkg::LVL_W-1:0] floor_q;
  logic [CIDX_W-1:0]         idx;

  car_t              mem [CARS];
  logic [CARS-1:0]   vld;
  car_t              rd_q;
  logic              rd_vld;

  logic [CIDX_W-1:0]           best_idx;
  logic [ebc_pkg::SCORE_W-1:0] best_score;
  car_t                        best;

  logic out_free;
  logic out_load;
  logic mem_we;
  logic [CIDX_W-1:0] mem_waddr;
  car_t mem_wdata;

  // Datapath results
  car_t                        cur;
  car_t                        t_next;
  logic                        t_door;
  car_t                        r_next;
  logic                        r_door;
  logic                        r_ok;
  logic [ebc_pkg::SCORE_W-1:0] cur_score;
  logic [IDXX_W-1:0]           idx_ext;
  logic [IDXX_W-1:0]           best_ext;
  logic                        report_en;
  logic                        report_last;

  logic                        o_kind;
  logic [ebc_pkg::CAR_W-1:0]   o_car;
  logic                        o_status;
  car_t                        o_entry;
  logic                        o_door;
  logic                        o_last;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign idx_ext  = {2'b00, idx};
  assign best_ext = {2'b00, best_idx};

  assign cur = rd_vld ? rd_q : car_t'{lvl: min_floor, dir: ebc_pkg::DIR_STAND, pend: '0};

  // Score of the car being visited for the held request floor
  always_comb begin
    cur_score = ebc_pkg::SCORE_MAX;
    if (cur.dir == ebc_pkg::DIR_STAND) begin
      cur_score = (cur.lvl > floor_q) ? {1'b0, cur.lvl - floor_q} : {1'b0, floor_q - cur.lvl};
    end else if (cur.dir == ebc_pkg::DIR_DOWN && cur.lvl > floor_q) begin
      cur_score = {1'b0, cur.lvl - floor_q};
    end else if (cur.dir == ebc_pkg::DIR_UP && cur.lvl < floor_q) begin
      cur_score = {1'b0, floor_q - cur.lvl};
    end
  end

  // Tick update of the visited car
  always_comb begin
    logic [FLOORS-1:0] lv_bit;
    logic [FLOORS-1:0] ge_mask;
    logic [FLOORS-1:0] le_mask;
    logic [FLOORS-1:0] rest;
    logic              enabled;
    logic              moving;
    logic              hit;
    for (int j = 0; j < FLOORS; j++) begin
      lv_bit[j]  = ({1'b0, cur.lvl} == (ebc_pkg::LVL_W + 1)'(j));
      ge_mask[j] = ((ebc_pkg::LVL_W + 1)'(j) >= {1'b0, cur.lvl});
      le_mask[j] = ((ebc_pkg::LVL_W + 1)'(j) <= {1'b0, cur.lvl});
    end
    enabled = ((idx_ext >> 2) == '0) && run_mask[idx_ext[1:0]];
    moving  = (cur.dir == ebc_pkg::DIR_UP) || (cur.dir == ebc_pkg::DIR_DOWN);
    hit     = (cur.pend & lv_bit) != '0;
    rest    = cur.pend & ~lv_bit;
    t_next  = cur;
    t_door  = 1'b0;
    if (enabled && moving) begin
      if (hit) begin
        t_door      = 1'b1;
        t_next.pend = rest;
        if (rest == '0) begin
          t_next.dir = ebc_pkg::DIR_STAND;
        end else if (cur.dir == ebc_pkg::DIR_UP) begin
          if ((rest & ge_mask) == '0) t_next.dir = ebc_pkg::DIR_DOWN;
        end else begin
          if ((rest & le_mask) == '0) t_next.dir = ebc_pkg::DIR_UP;
        end
      end else if (cur.dir == ebc_pkg::DIR_UP) begin
        if (cur.lvl < max_floor && {1'b0, cur.lvl} < TOP_FLOOR) begin
          t_next.lvl = cur.lvl + 1'b1;
        end
      end else begin
        if (cur.lvl > min_floor) t_next.lvl = cur.lvl - 1'b1;
      end
    end
  end

  // Request update of the chosen car
  always_comb begin
    logic [FLOORS-1:0] f_bit;
    for (int j = 0; j < FLOORS; j++) begin
      f_bit[j] = ({1'b0, floor_q} == (ebc_pkg::LVL_W + 1)'(j));
    end
    r_ok   = (floor_q >= min_floor) && (floor_q <= max_floor) && ({1'b0, floor_q} < FLOOR_LIMIT);
    r_next = best;
    r_door = 1'b0;
    if (best.pend == '0) begin
      if (floor_q > best.lvl) begin
        r_next.dir  = ebc_pkg::DIR_UP;
        r_next.pend = f_bit;
      end else if (floor_q < best.lvl) begin
        r_next.dir  = ebc_pkg::DIR_DOWN;
        r_next.pend = f_bit;
      end else begin
        r_next.dir = ebc_pkg::DIR_STAND;
        r_door     = 1'b1;
      end
    end else begin
      r_next.pend = best.pend | f_bit;
    end
  end

  assign report_en   = (idx_ext <= LAST_REPORT);
  assign report_last = (idx == LAST_CAR) || (idx_ext == LAST_REPORT);

  // Sequencer
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = t_next;
    o_kind     = ebc_pkg::KIND_REPORT;
    o_car      = idx_ext[ebc_pkg::CAR_W-1:0];
    o_status   = ebc_pkg::ST_OK;
    o_entry    = t_next;
    o_door     = t_door;
    o_last     = report_last;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (op_q == ebc_pkg::OP_TICK) begin
          if (!report_en || out_free) begin
            mem_we   = 1'b1;
            out_load = report_en;
            state_next = (idx == LAST_CAR) ? S_IDLE : S_READ;
          end
        end else begin
          state_next = (idx == LAST_CAR) ? S_REQ_DONE : S_READ;
        end
      end
      S_REQ_DONE: begin
        o_kind    = ebc_pkg::KIND_ANSWER;
        o_car     = best_ext[ebc_pkg::CAR_W-1:0];
        o_status  = r_ok ? ebc_pkg::ST_OK : ebc_pkg::ST_BAD_FLOOR;
        o_entry   = r_ok ? r_next : best;
        o_door    = r_ok && r_door;
        o_last    = 1'b1;
        mem_waddr = best_idx;
        mem_wdata = r_next;
        if (out_free) begin
          out_load   = 1'b1;
          mem_we     = r_ok;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      min_floor <= ebc_pkg::MIN_FLOOR_RST;
      max_floor <= ebc_pkg::MAX_FLOOR_RST;
      run_mask  <= ebc_pkg::RUN_MASK_RST;
      vld       <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          ebc_pkg::REG_MIN_FLOOR: min_floor <= cfg_wdata[ebc_pkg::LVL_W-1:0];
          ebc_pkg::REG_MAX_FLOOR: max_floor <= cfg_wdata[ebc_pkg::LVL_W-1:0];
          ebc_pkg::REG_RUN_MASK:  run_mask  <= cfg_wdata[ebc_pkg::RUN_W-1:0];
          default: ;
        endcase
      end
      // Re-home every car on a min_floor write
      if (cfg_we && cfg_addr == ebc_pkg::REG_MIN_FLOOR) begin
        vld <= '0;
      end else if (mem_we) begin
        vld[mem_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE) begin
        idx <= '0;
      end else if (state == S_EVAL && state_next == S_READ) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q    <= opcode;
      floor_q <= floor;
    end
    if (state == S_READ) begin
      rd_q   <= mem[idx];
      rd_vld <= vld[idx];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    // Keep the best car so far; ties stay with the lower index
    if (state == S_EVAL && op_q == ebc_pkg::OP_REQUEST) begin
      if (idx == '0 || cur_score < best_score) begin
        best_score <= cur_score;
        best_idx   <= idx;
        best       <= cur;
      end
    end
    if (out_load) begin
      kind        <= o_kind;
      car         <= o_car;
      status      <= o_status;
      level       <= o_entry.lvl;
      direction   <= o_entry.dir;
      door_opened <= o_door;
      last        <= o_last;
    end
  end

endmodule

FILE: tb/ebc_checker.sv
`timescale 1ns / 1ps

module ebc_checker #(
  parameter int CARS = ebc_pkg::DEF_CARS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           opcode,
  input  logic [ebc_pkg::LVL_W-1:0]      floor,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           kind,
  input  logic [ebc_pkg::CAR_W-1:0]      car,
  input  logic                           status,
  input  logic [ebc_pkg::LVL_W-1:0]      level,
  input  logic [ebc_pkg::DIR_W-1:0]      direction,
  input  logic                           door_opened,
  input  logic                           last,
  input  logic                           cfg_we,
  input  logic [ebc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ebc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             errors,
  output int                             outstanding,
  output int                             checked
);

  typedef struct {
    logic                      kind;
    logic [ebc_pkg::CAR_W-1:0] car;
    logic                      status;
    logic [ebc_pkg::LVL_W-1:0] level;
    logic [ebc_pkg::DIR_W-1:0] direction;
    logic                      door_opened;
    logic                      last;
  } car_result_t;

  localparam int NO_SCORE = 32'h7fff_ffff;

  car_result_t               results_due[$];
  logic [ebc_pkg::LVL_W-1:0] lo_floor;
  logic [ebc_pkg::LVL_W-1:0] hi_floor;
  logic [ebc_pkg::RUN_W-1:0] run_bits;
  logic [ebc_pkg::LVL_W-1:0] car_at  [CARS];
  logic [ebc_pkg::DIR_W-1:0] car_dir [CARS];
  logic [63:0]               calls   [CARS];
  int                        fail_n = 0;
  int                        seen_n = 0;

  function automatic int call_score(int c, int f);
    int lv;
    lv = car_at[c];
    if (car_dir[c] == ebc_pkg::DIR_STAND) return (lv > f) ? lv - f : f - lv;
    if (car_dir[c] == ebc_pkg::DIR_DOWN && lv > f) return lv - f;
    if (car_dir[c] == ebc_pkg::DIR_UP && lv < f) return f - lv;
    return NO_SCORE;
  endfunction

  task automatic rehome_cars();
    for (int c = 0; c < CARS; c++) begin
      car_at[c]  = lo_floor;
      car_dir[c] = ebc_pkg::DIR_STAND;
      calls[c]   = '0;
    end
  endtask

  task automatic queue_result(input logic k, input int c, input logic st,
                              input logic door, input logic fin);
    car_result_t r;
    r.kind        = k;
    r.car         = c[ebc_pkg::CAR_W-1:0];
    r.status      = st;
    r.level       = car_at[c];
    r.direction   = car_dir[c];
    r.door_opened = door;
    r.last        = fin;
    results_due = {results_due, r};
  endtask

  task automatic dispatch_call(input logic [ebc_pkg::LVL_W-1:0] f);
    int   best;
    int   best_score;
    int   s;
    logic door;
    best       = 0;
    best_score = call_score(0, f);
    door       = 1'b0;
    for (int c = 1; c < CARS; c++) begin
      s = call_score(c, f);
      if (s < best_score) begin
        best_score = s;
        best       = c;
      end
    end
    if (f < lo_floor || f > hi_floor) begin
      queue_result(ebc_pkg::KIND_ANSWER, best, ebc_pkg::ST_BAD_FLOOR, 1'b0, 1'b1);
      return;
    end
    if (calls[best] == '0) begin
      if (f > car_at[best]) begin
        car_dir[best] = ebc_pkg::DIR_UP;
        calls[best]   = 64'd1 << f;
      end else if (f < car_at[best]) begin
        car_dir[best] = ebc_pkg::DIR_DOWN;
        calls[best]   = 64'd1 << f;
      end else begin
        // already there: serve on the spot
        car_dir[best] = ebc_pkg::DIR_STAND;
        door          = 1'b1;
      end
    end else begin
      calls[best] = calls[best] | (64'd1 << f);
    end
    queue_result(ebc_pkg::KIND_ANSWER, best, ebc_pkg::ST_OK, door, 1'b1);
  endtask

  task automatic advance_cars();
    logic [63:0]               here;
    logic [63:0]               below_mask;
    logic [ebc_pkg::LVL_W-1:0] lv;
    logic                      door;
    for (int c = 0; c < CARS; c++) begin
      door = 1'b0;
      lv   = car_at[c];
      if (run_bits[c] && (car_dir[c] == ebc_pkg::DIR_UP || car_dir[c] == ebc_pkg::DIR_DOWN))
      begin
        here       = 64'd1 << lv;
        below_mask = {64{1'b1}} >> (6'd63 - lv);
        if ((calls[c] & here) != '0) begin
          calls[c] = calls[c] & ~here;
          door     = 1'b1;
          if (calls[c] == '0) begin
            car_dir[c] = ebc_pkg::DIR_STAND;
          end else if (car_dir[c] == ebc_pkg::DIR_UP) begin
            if ((calls[c] >> lv) == '0) car_dir[c] = ebc_pkg::DIR_DOWN;
          end else begin
            if ((calls[c] & below_mask) == '0) car_dir[c] = ebc_pkg::DIR_UP;
          end
        end else if (car_dir[c] == ebc_pkg::DIR_UP) begin
          if (lv < hi_floor && lv < 6'd63) car_at[c] = lv + 6'd1;
        end else begin
          if (lv > lo_floor) car_at[c] = lv - 6'd1;
        end
      end
      if (c < ebc_pkg::MAX_REPORTS) begin
        queue_result(ebc_pkg::KIND_REPORT, c, ebc_pkg::ST_OK, door,
                     (c == CARS - 1) || (c == ebc_pkg::MAX_REPORTS - 1));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_n++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    car_result_t r;
    if (rst) begin
      lo_floor = ebc_pkg::MIN_FLOOR_RST;
      hi_floor = ebc_pkg::MAX_FLOOR_RST;
      run_bits = ebc_pkg::RUN_MASK_RST;
      rehome_cars();
      results_due.delete();
    end else begin
      // retire before predicting, so an empty store is never confused
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          fail_n++;
          $display("%0t: unexpected item, expected none, actual car %0d kind %0d level %0d",
                   $time, car, kind, level);
        end else begin
          r = results_due.pop_front();
          seen_n++;
          check_field("kind", r.kind, kind);
          check_field("car", r.car, car);
          check_field("status", r.status, status);
          check_field("level", r.level, level);
          check_field("direction", r.direction, direction);
          check_field("door_opened", r.door_opened, door_opened);
          check_field("last", r.last, last);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          ebc_pkg::REG_MIN_FLOOR: begin
            lo_floor = cfg_wdata;
            rehome_cars();
          end
          ebc_pkg::REG_MAX_FLOOR: hi_floor = cfg_wdata;
          ebc_pkg::REG_RUN_MASK:  run_bits = cfg_wdata[ebc_pkg::RUN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (opcode == ebc_pkg::OP_REQUEST) dispatch_call(floor);
        else advance_cars();
      end
    end
    errors      <= fail_n;
    outstanding <= results_due.size();
    checked     <= seen_n;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [ebc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic                           opcode;
  logic [ebc_pkg::LVL_W-1:0]      floor;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           kind;
  logic [ebc_pkg::CAR_W-1:0]      car;
  logic                           status;
  logic [ebc_pkg::LVL_W-1:0]      level;
  logic [ebc_pkg::DIR_W-1:0]      direction;
  logic                           door_opened;
  logic                           last;
  logic                           cfg_we;
  logic [ebc_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [ebc_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             errors;
  int                             outstanding;
  int                             checked;

  int send_idle  = 34;
  int recv_idle  = 71;
  int n_requests = 0;
  int n_ticks    = 0;
  int n_settings = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  elevator_bank_controller DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .floor(floor),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .car(car),
    .status(status), .level(level), .direction(direction),
    .door_opened(door_opened), .last(last),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  ebc_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .floor(floor),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .car(car),
    .status(status), .level(level), .direction(direction),
    .door_opened(door_opened), .last(last),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .errors(errors), .outstanding(outstanding), .checked(checked)
  );

  always @(posedge clk) out_ready <= ($urandom_range(99, 0) >= recv_idle);

  task automatic push_item(input logic op, input logic [ebc_pkg::LVL_W-1:0] fl);
    // idle with junk on the payload
    while ($urandom_range(99, 0) < send_idle) begin
      in_valid <= 1'b0;
      opcode   <= 1'($urandom_range(1, 0));
      floor    <= 6'($urandom_range(63, 0));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    floor    <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == ebc_pkg::OP_REQUEST) n_requests++;
    else n_ticks++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ebc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ebc_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [ebc_pkg::LVL_W-1:0] lo,
                               input logic [ebc_pkg::LVL_W-1:0] hi,
                               input logic [ebc_pkg::CFG_DATA_W-1:0] mask);
    write_reg(ebc_pkg::REG_MIN_FLOOR, lo);
    write_reg(ebc_pkg::REG_MAX_FLOOR, hi);
    write_reg(ebc_pkg::REG_RUN_MASK, mask);
    n_settings++;
  endtask

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [ebc_pkg::LVL_W-1:0]      lo;
    logic [ebc_pkg::LVL_W-1:0]      hi;
    logic [ebc_pkg::CFG_DATA_W-1:0] mask;
    int                             pick;
    int                             span;
    rst       = 1'b1;
    in_valid  = 1'b0;
    opcode    = ebc_pkg::OP_REQUEST;
    floor     = '0;
    cfg_we    = 1'b0;
    cfg_addr  = ebc_pkg::REG_MIN_FLOOR;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // out-of-range calls, serve on the spot, duplicate, then travel and stops
    apply_setting(6'd1, 6'd10, 6'h0f);
    push_item(ebc_pkg::OP_REQUEST, 6'd0);
    push_item(ebc_pkg::OP_REQUEST, 6'd63);
    push_item(ebc_pkg::OP_REQUEST, 6'd1);
    push_item(ebc_pkg::OP_REQUEST, 6'd5);
    push_item(ebc_pkg::OP_REQUEST, 6'd5);
    push_item(ebc_pkg::OP_REQUEST, 6'd3);
    push_item(ebc_pkg::OP_REQUEST, 6'd8);
    repeat (6) push_item(ebc_pkg::OP_TICK, 6'd0);
    push_item(ebc_pkg::OP_REQUEST, 6'd2);
    repeat (4) push_item(ebc_pkg::OP_TICK, 6'd0);
    drain();

    // re-home high, partial run mask, then hold a climbing car at the top bound
    apply_setting(6'd16, 6'd63, 6'h35);
    push_item(ebc_pkg::OP_REQUEST, 6'd63);
    push_item(ebc_pkg::OP_REQUEST, 6'd16);
    push_item(ebc_pkg::OP_REQUEST, 6'd20);
    drain();
    write_reg(ebc_pkg::REG_MAX_FLOOR, 6'd18);
    repeat (4) push_item(ebc_pkg::OP_TICK, 6'd0);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 71;
        recv_idle <= 34;
      end
      if (p == 4) begin
        send_idle = 0;
        recv_idle <= 0;
      end
      span = 43;
      case (p)
        0: begin lo = 6'd0;  hi = 6'd63; mask = 6'h0f; end
        1: begin lo = 6'd30; hi = 6'd20; mask = 6'h0f; span = 20; end
        2: begin lo = 6'd63; hi = 6'd63; mask = 6'($urandom_range(63, 0)); end
        3: begin lo = 6'd5;  hi = 6'd12; mask = 6'($urandom_range(63, 0)); end
        4: begin lo = 6'd1;  hi = 6'd10; mask = 6'h30; end
        default: begin
          lo   = 6'($urandom_range(31, 0));
          hi   = 6'($urandom_range(63, 32));
          mask = 6'($urandom_range(63, 0));
        end
      endcase
      apply_setting(lo, hi, mask);
      // a write to the spare index must leave everything alone
      if (p == 3) write_reg(REG_UNUSED, 6'($urandom_range(63, 0)));
      for (int i = 0; i < span; i++) begin
        pick = $urandom_range(99, 0);
        if (pick < 45) push_item(ebc_pkg::OP_TICK, 6'($urandom_range(63, 0)));
        else if (pick < 90 && lo <= hi)
          push_item(ebc_pkg::OP_REQUEST, 6'($urandom_range(hi, lo)));
        else push_item(ebc_pkg::OP_REQUEST, 6'($urandom_range(63, 0)));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d hall calls and %0d ticks over %0d register settings",
             n_requests, n_ticks, n_settings);
    $display("compared %0d result items under three back-pressure profiles", checked);
    if (errors == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ebc_pkg.sv
rtl/elevator_bank_controller.sv
tb/ebc_checker.sv
tb/tb_top.sv
